[hdl/dbrs_pkg.sv]
// Shared types, constants and frame byte table for the doorbell repeat sender.
package dbrs_pkg;

    localparam int TICKS_PER_SECOND = 10000;
    localparam logic [15:0] SECOND_TICKS = 16'(TICKS_PER_SECOND);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] BS_UNKNOWN  = 2'd0;
    localparam logic [1:0] BS_PRESSED  = 2'd1;
    localparam logic [1:0] BS_RELEASED = 2'd2;
    localparam logic [1:0] BS_INVALID  = 2'd3;

    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_QUERY = 8'h3F;

    localparam logic [3:0] FRAME_LAST = 4'd9;

    typedef enum logic [1:0] {
        CFG_FORCE_SECS         = 2'd0,
        CFG_FORCE_UNKNOWN_SECS = 2'd1,
        CFG_REPEAT_COUNT       = 2'd2,
        CFG_SPACING_TICKS      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] now_ticks;
        logic [1:0]  btn_state;
    } t_poll;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
    } t_result;

    // the two variable bytes of one frame
    typedef struct packed {
        logic [7:0] state_char;
        logic [7:0] seq_char;
    } t_frame_desc;

    typedef struct packed {
        logic       we;
        t_cfg_idx   idx;
        logic [15:0] data;
    } t_cfg_wr;

    // byte at position idx of "$DBL,<s>,<q>\r\n"
    function automatic logic [7:0] dbrs_frame_byte(input logic [3:0] idx,
                                                   input t_frame_desc d);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h24;
            4'd1:    b = 8'h44;
            4'd2:    b = 8'h42;
            4'd3:    b = 8'h4C;
            4'd4:    b = 8'h2C;
            4'd5:    b = d.state_char;
            4'd6:    b = 8'h2C;
            4'd7:    b = d.seq_char;
            4'd8:    b = 8'h0D;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

endpackage

[hdl/dbrs_front.sv]
// Poll front end: configuration registers, silence timer, repeat scheduling.
module dbrs_front
    import dbrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg_wr     i_cfg,
    input  logic        i_accept,
    input  t_poll       i_poll,
    output logic        o_emit,
    output t_frame_desc o_desc
);

    logic [7:0]  r_force_secs;
    logic [7:0]  r_force_unk_secs;
    logic [3:0]  r_repeat;
    logic [15:0] r_spacing;

    logic [1:0]  r_last_state, n_last_state;
    logic [4:0]  r_pending,    n_pending;
    logic        r_forced,     n_forced;
    logic        r_seen,       n_seen;
    logic [15:0] r_last_send,  n_last_send;
    logic [7:0]  r_silent,     n_silent;
    logic [15:0] r_sec_mark,   n_sec_mark;

    always_comb begin
        logic [1:0]  bs;
        logic [7:0]  silent_inc;
        logic [4:0]  rep5;
        logic        is_on;
        logic        is_off;
        logic [7:0]  seq;

        n_last_state = r_last_state;
        n_pending    = r_pending;
        n_forced     = r_forced;
        n_seen       = r_seen;
        n_last_send  = r_last_send;
        n_silent     = r_silent;
        n_sec_mark   = r_sec_mark;
        o_emit       = 1'b0;
        o_desc       = '0;
        rep5         = {1'b0, r_repeat};
        bs           = (i_poll.btn_state == BS_INVALID) ? BS_UNKNOWN
                                                        : i_poll.btn_state;
        silent_inc   = r_silent + 8'd1;
        is_on        = 1'b0;
        is_off       = 1'b0;
        seq          = '0;

        if (i_accept) begin
            // one-second tick of the silence counter
            if (r_seen && ((i_poll.now_ticks - r_sec_mark) > SECOND_TICKS)) begin
                n_silent   = silent_inc;
                n_sec_mark = r_sec_mark + SECOND_TICKS;
                if (((bs == BS_UNKNOWN) && (silent_inc > r_force_unk_secs)) ||
                    (silent_inc > r_force_secs)) begin
                    n_pending = rep5;
                    n_forced  = 1'b1;
                    n_silent  = '0;
                end
            end

            if ((bs != BS_UNKNOWN) && (bs != r_last_state)) begin
                n_seen       = 1'b1;
                n_last_state = bs;
                if (bs == BS_PRESSED) begin
                    n_pending   = {r_repeat, 1'b0};
                    n_last_send = i_poll.now_ticks - r_spacing;
                    n_forced    = 1'b0;
                end else if (n_pending < rep5) begin
                    n_pending = rep5;
                    n_forced  = 1'b0;
                end
            end

            if ((n_pending != '0) && ((i_poll.now_ticks - n_last_send) >= r_spacing)) begin
                n_last_send = i_poll.now_ticks;
                is_on  = n_pending > rep5;
                is_off = (n_last_state == BS_RELEASED) || n_forced;
                if (is_on || is_off) begin
                    seq = (is_on ? {3'b000, r_repeat, 1'b0} : {4'b0000, r_repeat})
                          - {3'b000, n_pending};
                    o_desc.seq_char = CH_ZERO + seq;
                    if (is_on) begin
                        o_desc.state_char = CH_ONE;
                    end else if (n_forced && (bs == BS_UNKNOWN)) begin
                        o_desc.state_char = CH_QUERY;
                    end else begin
                        o_desc.state_char = CH_ZERO;
                    end
                    o_emit    = 1'b1;
                    n_pending = n_pending - 5'd1;
                    n_silent  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_secs     <= 8'd120;
            r_force_unk_secs <= 8'd10;
            r_repeat         <= 4'd5;
            r_spacing        <= 16'd500;
            r_last_state     <= BS_UNKNOWN;
            r_pending        <= '0;
            r_forced         <= 1'b0;
            r_seen           <= 1'b0;
            r_last_send      <= '0;
            r_silent         <= 8'd120;
            r_sec_mark       <= '0;
        end else begin
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    CFG_FORCE_SECS:         r_force_secs     <= i_cfg.data[7:0];
                    CFG_FORCE_UNKNOWN_SECS: r_force_unk_secs <= i_cfg.data[7:0];
                    CFG_REPEAT_COUNT:       r_repeat         <= i_cfg.data[3:0];
                    CFG_SPACING_TICKS:      r_spacing        <= i_cfg.data;
                endcase
            end
            r_last_state <= n_last_state;
            r_pending    <= n_pending;
            r_forced     <= n_forced;
            r_seen       <= n_seen;
            r_last_send  <= n_last_send;
            r_silent     <= n_silent;
            r_sec_mark   <= n_sec_mark;
        end
    end

endmodule

[hdl/dbrs_fifo.sv]
// Short frame descriptor queue between the front end and the serializer.
module dbrs_fifo
    import dbrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  t_frame_desc i_wr_data,
    output logic        o_full,
    input  logic        i_rd,
    output t_frame_desc o_rd_data,
    output logic        o_empty
);

    t_frame_desc             r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     r_wr_ptr;
    logic [QUEUE_AW-1:0]     r_rd_ptr;
    logic [QUEUE_AW:0]       r_count;

    assign o_full    = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + (QUEUE_AW)'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + (QUEUE_AW)'(1);
            end
            unique case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[hdl/dbrs_serializer.sv]
// Frame serializer: expands one descriptor into ten bytes behind an output register.
module dbrs_serializer
    import dbrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_frame_desc i_q_data,
    output logic        o_q_pop,
    output logic        o_empty,
    input  logic        i_pop,
    output t_result     o_result
);

    logic        r_busy;
    logic [3:0]  r_idx;
    t_frame_desc r_desc;
    logic        r_out_vld;
    t_result     r_out;

    logic take;
    logic last;
    logic load;

    // advance one byte whenever the output register is free or draining
    assign take    = r_busy && (!r_out_vld || i_pop);
    assign last    = take && (r_idx == FRAME_LAST);
    assign load    = !i_q_empty && (!r_busy || last);
    assign o_q_pop = load;

    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_desc <= i_q_data;
        end
        if (take) begin
            r_out.tx_byte   <= dbrs_frame_byte(r_idx, r_desc);
            r_out.frame_end <= (r_idx == FRAME_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (take) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (last) begin
                r_busy <= 1'b0;
            end else if (take) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

endmodule

[hdl/doorbell_event_repeat_sender.sv]
// A poll that sends a frame passes the descriptor queue, the serializer's descriptor
// register and the output register before its first byte shows. One poll per cycle is
// taken while the queue has room; bytes leave one per cycle while they are popped.
// full rises when the four-entry descriptor queue is full.
// Reset (synchronous, active low) restores register defaults and empties the queue.
module doorbell_event_repeat_sender
    import dbrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  t_poll       i_poll,
    output logic        empty,
    input  logic        pop,
    output t_result     o_result
);

    t_cfg_wr     cfg;
    logic        accept;
    logic        emit;
    t_frame_desc desc;
    logic        q_empty;
    logic        q_pop;
    t_frame_desc q_data;

    assign cfg    = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};
    assign accept = push && !full;

    dbrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_poll   (i_poll),
        .o_emit   (emit),
        .o_desc   (desc)
    );

    dbrs_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (emit),
        .i_wr_data (desc),
        .o_full    (full),
        .i_rd      (q_pop),
        .o_rd_data (q_data),
        .o_empty   (q_empty)
    );

    dbrs_serializer u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule
